@@ hw/rtl/rwl_pkg.sv @@
// Shared types, sizes and codes for the reader-writer lock manager.
package rwl_pkg;

	// Sizing
	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_SHARED  = 255;
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int HW = $clog2(MAX_SHARED + 1);
	localparam int SW = CW + 1;
	localparam int TAG_W = 8;

	// Request functions
	typedef enum logic [2:0] {
		F_LOCK_EX   = 3'd0,
		F_LOCK_SH   = 3'd1,
		F_TRY_EX    = 3'd2,
		F_TRY_SH    = 3'd3,
		F_UNLOCK_EX = 3'd4,
		F_UNLOCK_SH = 3'd5
	} func_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_ACQUIRED = 3'd0,
		ST_QUEUED   = 3'd1,
		ST_REFUSED  = 3'd2,
		ST_RELEASED = 3'd3,
		ST_MISUSE   = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	// Result kinds
	typedef enum logic {
		K_REPLY = 1'b0,
		K_GRANT = 1'b1
	} kind_t;

	// Input transfer payload
	typedef struct packed {
		logic [2:0]       func;
		logic [TAG_W-1:0] request_tag;
	} req_t;

	// Result transfer payload
	typedef struct packed {
		logic             kind;
		logic [2:0]       status;
		logic [TAG_W-1:0] grant_tag;
		logic             grant_shared;
		logic             last;
	} res_t;

endpackage

@@ hw/rtl/reader_writer_lock_manager_top.sv @@
// Reader-writer lock manager: FIFO waiter queue in a synchronous memory.
// The reply is registered and strobes in the cycle after the request transfer.
// A request that resumes no waiter leaves busy low, so the next request can follow; a release
// that resumes waiters holds busy through S_READ and S_RUN (one read of the queue memory per
// grant), and through S_FLUSH where a shared run ends, and takes no request meanwhile.
// Reset clears holder, queue and segment counters at once; queue memory is not cleared.
// Results are strobed for one cycle; the receiver cannot stall them.
module reader_writer_lock_manager_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rwl_pkg::req_t request,
	output logic          busy,
	output logic          valid,
	output rwl_pkg::res_t result
);
	import rwl_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_RUN   = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

	// Control state
	state_t        state_q, n_state;
	logic [HW-1:0] holder_q, n_holder;
	logic          excl_q, n_excl;
	logic [QW-1:0] head_q, n_head;
	logic [CW-1:0] count_q, n_count;
	logic [CW-1:0] pend_q, n_pend;
	logic          first_q, n_first;
	logic          valid_q, n_valid;

	// Payload registers
	res_t             result_q, n_result;
	logic [TAG_W-1:0] hold_tag_q, n_hold_tag;
	logic [TAG_W:0]   rd_q;

	// Queue memory: {shared, tag}
	logic [TAG_W:0] mem [QUEUE_DEPTH];
	logic           push_en;
	logic [QW-1:0]  push_slot;
	logic [TAG_W:0] push_data;
	logic [QW-1:0]  rd_addr;

	logic          accept;
	logic          free_excl, free_sh;
	logic [QW-1:0] head_inc;
	logic [SW-1:0] slot_sum;
	logic          e_sh;
	logic          cont;

	assign accept    = start && (state_q == S_IDLE);
	assign free_excl = (holder_q == '0) && !excl_q;
	assign free_sh   = !excl_q && (count_q == '0);
	assign head_inc  = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign slot_sum  = SW'(head_q) + SW'(count_q);
	assign push_slot = (slot_sum >= SW'(QUEUE_DEPTH)) ?
		QW'(slot_sum - SW'(QUEUE_DEPTH)) : QW'(slot_sum);
	assign e_sh      = rd_q[TAG_W];
	assign cont      = (pend_q != CW'(1)) && (holder_q < HW'(MAX_SHARED - 1));

	// Request decode and resumption sequencer
	always_comb begin
		n_state    = state_q;
		n_holder   = holder_q;
		n_excl     = excl_q;
		n_head     = head_q;
		n_count    = count_q;
		n_pend     = pend_q;
		n_first    = first_q;
		n_valid    = 1'b0;
		n_result   = result_q;
		n_hold_tag = hold_tag_q;
		push_en    = 1'b0;
		push_data  = {1'b0, request.request_tag};
		rd_addr    = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					n_valid               = 1'b1;
					n_result.kind         = K_REPLY;
					n_result.grant_tag    = request.request_tag;
					n_result.grant_shared = 1'b0;
					n_result.last         = 1'b1;
					n_result.status       = ST_MISUSE;
					unique case (request.func)
						F_LOCK_EX, F_TRY_EX: begin
							if (free_excl) begin
								n_excl          = 1'b1;
								n_result.status = ST_ACQUIRED;
							end else if (request.func == F_TRY_EX) begin
								n_result.status = ST_REFUSED;
							end else if (count_q == CW'(QUEUE_DEPTH)) begin
								n_result.status = ST_FULL;
							end else begin
								push_en         = 1'b1;
								push_data       = {1'b0, request.request_tag};
								n_count         = count_q + 1'b1;
								n_result.status = ST_QUEUED;
							end
						end
						F_LOCK_SH, F_TRY_SH: begin
							if (free_sh) begin
								if (holder_q < HW'(MAX_SHARED)) begin
									n_holder        = holder_q + 1'b1;
									n_result.status = ST_ACQUIRED;
								end else begin
									n_result.status = ST_REFUSED;
								end
							end else if (request.func == F_TRY_SH) begin
								n_result.status = ST_REFUSED;
							end else if (count_q == CW'(QUEUE_DEPTH)) begin
								n_result.status = ST_FULL;
							end else begin
								push_en         = 1'b1;
								push_data       = {1'b1, request.request_tag};
								n_count         = count_q + 1'b1;
								n_result.status = ST_QUEUED;
							end
						end
						F_UNLOCK_EX: begin
							if (excl_q) begin
								n_excl          = 1'b0;
								n_result.status = ST_RELEASED;
								if (count_q != '0) begin
									n_result.last = 1'b0;
									n_state       = S_READ;
									if (pend_q == '0) n_pend = count_q;
								end
							end
						end
						F_UNLOCK_SH: begin
							if (!excl_q && holder_q != '0) begin
								n_holder        = holder_q - 1'b1;
								n_result.status = ST_RELEASED;
								if (holder_q == HW'(1) && count_q != '0) begin
									n_result.last = 1'b0;
									n_state       = S_READ;
									if (pend_q == '0) n_pend = count_q;
								end
							end
						end
						default: n_result.status = ST_MISUSE;
					endcase
				end
			end
			S_READ: begin
				rd_addr = head_q;
				n_first = 1'b1;
				n_state = S_RUN;
			end
			S_RUN: begin
				n_result.kind   = K_GRANT;
				n_result.status = ST_ACQUIRED;
				if (first_q && !e_sh) begin
					// exclusive head is granted alone
					n_valid               = 1'b1;
					n_result.grant_tag    = rd_q[TAG_W-1:0];
					n_result.grant_shared = 1'b0;
					n_result.last         = 1'b1;
					n_excl                = 1'b1;
					n_head                = head_inc;
					n_count               = count_q - 1'b1;
					n_pend                = pend_q - 1'b1;
					n_state               = S_IDLE;
				end else if (e_sh) begin
					// shared waiter joins the run; previous grant goes out
					if (!first_q) begin
						n_valid               = 1'b1;
						n_result.grant_tag    = hold_tag_q;
						n_result.grant_shared = 1'b1;
						n_result.last         = 1'b0;
					end
					n_hold_tag = rd_q[TAG_W-1:0];
					n_holder   = holder_q + 1'b1;
					n_head     = head_inc;
					n_count    = count_q - 1'b1;
					n_pend     = pend_q - 1'b1;
					n_first    = 1'b0;
					rd_addr    = head_inc;
					n_state    = cont ? S_RUN : S_FLUSH;
				end else begin
					// exclusive waiter ends the shared run
					n_valid               = 1'b1;
					n_result.grant_tag    = hold_tag_q;
					n_result.grant_shared = 1'b1;
					n_result.last         = 1'b1;
					n_state               = S_IDLE;
				end
			end
			S_FLUSH: begin
				n_valid               = 1'b1;
				n_result.kind         = K_GRANT;
				n_result.status       = ST_ACQUIRED;
				n_result.grant_tag    = hold_tag_q;
				n_result.grant_shared = 1'b1;
				n_result.last         = 1'b1;
				n_state               = S_IDLE;
			end
			default: n_state = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			holder_q <= '0;
			excl_q   <= 1'b0;
			head_q   <= '0;
			count_q  <= '0;
			pend_q   <= '0;
			first_q  <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			state_q  <= n_state;
			holder_q <= n_holder;
			excl_q   <= n_excl;
			head_q   <= n_head;
			count_q  <= n_count;
			pend_q   <= n_pend;
			first_q  <= n_first;
			valid_q  <= n_valid;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		result_q   <= n_result;
		hold_tag_q <= n_hold_tag;
	end

	// Queue memory, registered read
	always_ff @(posedge clk) begin
		if (push_en) mem[push_slot] <= push_data;
		rd_q <= mem[rd_addr];
	end

	assign busy   = (state_q != S_IDLE);
	assign valid  = valid_q;
	assign result = result_q;

	// Checks
	a_grant_acquired: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result.kind == K_GRANT |-> result.status == ST_ACQUIRED)
		else $error("grant with status other than acquired");
	a_excl_alone: assert property (@(posedge clk) disable iff (!arst_n)
		!(excl_q && holder_q != '0))
		else $error("exclusive holder alongside shared holders");
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH) && pend_q <= count_q)
		else $error("queue or segment count out of range");
	a_reply_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> valid && result.kind == K_REPLY)
		else $error("accepted request without reply");
	a_read_then_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> state_q == S_RUN && first_q)
		else $error("queue read not followed by grant step");

endmodule

@@ dv/tb_reader_writer_lock_manager_top.sv @@
// Self-checking testbench for the reader-writer lock manager: directed and random request streams.
`timescale 1ns / 1ps

module tb_reader_writer_lock_manager_top;
	import rwl_pkg::*;

	// Function codes outside the defined set
	localparam logic [2:0] F_UNDEF_LO = 3'd6;
	localparam logic [2:0] F_UNDEF_HI = 3'd7;

	// Cycles with no transfer on either side before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 24;
	localparam int ITEMS_PER_PHASE = 42;

	// Tracks lock ownership and the waiter queue; holds the results still due
	class lock_tracker;
		int unsigned      holders;
		bit               excl_held;
		logic [TAG_W-1:0] wait_tag [QUEUE_DEPTH];
		bit               wait_sh [QUEUE_DEPTH];
		int unsigned      head;
		int unsigned      waiting;
		int unsigned      segment;
		res_t             due_results [$];
		int unsigned      fail_count;

		function new();
			holders    = 0;
			excl_held  = 0;
			head       = 0;
			waiting    = 0;
			segment    = 0;
			fail_count = 0;
		endfunction

		function void post(kind_t k, status_t s, logic [TAG_W-1:0] tag, bit sh);
			res_t r;
			r.kind         = k;
			r.status       = s;
			r.grant_tag    = tag;
			r.grant_shared = sh;
			r.last         = 1'b0;
			due_results.push_back(r);
		endfunction

		function bit enqueue(logic [TAG_W-1:0] tag, bit sh);
			int unsigned slot;
			if (waiting >= QUEUE_DEPTH)
				return 1'b0;
			slot = (head + waiting) % QUEUE_DEPTH;
			wait_tag[slot] = tag;
			wait_sh[slot]  = sh;
			waiting++;
			return 1'b1;
		endfunction

		function void dequeue();
			head = (head + 1) % QUEUE_DEPTH;
			waiting--;
			segment--;
		endfunction

		// Lock just became free: grant the head waiter, or a run of shared ones
		function void wake_waiters();
			if (segment == 0)
				segment = waiting;
			if (segment == 0)
				return;
			if (!wait_sh[head]) begin
				excl_held = 1'b1;
				post(K_GRANT, ST_ACQUIRED, wait_tag[head], 1'b0);
				dequeue();
				return;
			end
			while (segment > 0 && holders < MAX_SHARED && wait_sh[head]) begin
				holders++;
				post(K_GRANT, ST_ACQUIRED, wait_tag[head], 1'b1);
				dequeue();
			end
		endfunction

		// Accepted request: work out the reply and any grants it triggers
		function void note_request(req_t rq);
			bit   free_excl;
			bit   free_sh;
			res_t tail;
			free_excl = (holders == 0) && !excl_held;
			free_sh   = !excl_held && (waiting == 0);
			case (rq.func)
				F_LOCK_EX, F_TRY_EX: begin
					if (free_excl) begin
						excl_held = 1'b1;
						post(K_REPLY, ST_ACQUIRED, rq.request_tag, 1'b0);
					end else if (rq.func == F_TRY_EX) begin
						post(K_REPLY, ST_REFUSED, rq.request_tag, 1'b0);
					end else if (enqueue(rq.request_tag, 1'b0)) begin
						post(K_REPLY, ST_QUEUED, rq.request_tag, 1'b0);
					end else begin
						post(K_REPLY, ST_FULL, rq.request_tag, 1'b0);
					end
				end
				F_LOCK_SH, F_TRY_SH: begin
					if (free_sh) begin
						if (holders < MAX_SHARED) begin
							holders++;
							post(K_REPLY, ST_ACQUIRED, rq.request_tag, 1'b0);
						end else begin
							post(K_REPLY, ST_REFUSED, rq.request_tag, 1'b0);
						end
					end else if (rq.func == F_TRY_SH) begin
						post(K_REPLY, ST_REFUSED, rq.request_tag, 1'b0);
					end else if (enqueue(rq.request_tag, 1'b1)) begin
						post(K_REPLY, ST_QUEUED, rq.request_tag, 1'b0);
					end else begin
						post(K_REPLY, ST_FULL, rq.request_tag, 1'b0);
					end
				end
				F_UNLOCK_EX: begin
					if (!excl_held) begin
						post(K_REPLY, ST_MISUSE, rq.request_tag, 1'b0);
					end else begin
						excl_held = 1'b0;
						post(K_REPLY, ST_RELEASED, rq.request_tag, 1'b0);
						wake_waiters();
					end
				end
				F_UNLOCK_SH: begin
					if (excl_held || holders == 0) begin
						post(K_REPLY, ST_MISUSE, rq.request_tag, 1'b0);
					end else begin
						holders--;
						post(K_REPLY, ST_RELEASED, rq.request_tag, 1'b0);
						if (holders == 0)
							wake_waiters();
					end
				end
				default: begin
					post(K_REPLY, ST_MISUSE, rq.request_tag, 1'b0);
				end
			endcase
			// Flag the final result of this request
			tail = due_results.pop_back();
			tail.last = 1'b1;
			due_results.push_back(tail);
		endfunction

		// Compare one strobed result against the oldest one due
		function void check_result(res_t got);
			res_t want;
			if (due_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("%0t: unexpected result", $time);
					$display("  actual   kind %0d status %0d tag %02h shared %0d last %0d",
						got.kind, got.status, got.grant_tag, got.grant_shared, got.last);
				end
				return;
			end
			want = due_results.pop_front();
			if (got.kind !== want.kind || got.status !== want.status ||
			    got.grant_tag !== want.grant_tag ||
			    got.grant_shared !== want.grant_shared || got.last !== want.last) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("%0t: result mismatch", $time);
					$display("  expected kind %0d status %0d tag %02h shared %0d last %0d",
						want.kind, want.status, want.grant_tag, want.grant_shared, want.last);
					$display("  actual   kind %0d status %0d tag %02h shared %0d last %0d",
						got.kind, got.status, got.grant_tag, got.grant_shared, got.last);
				end
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  start;
	req_t  request;
	logic  busy;
	logic  valid;
	res_t  result;

	lock_tracker sb;
	int unsigned quiet_cycles;

	reader_writer_lock_manager_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.valid  (valid),
		.result (result)
	);

	// Clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Drive one request and hold it until the block takes it; start stays high
	task automatic issue(input logic [2:0] f, input logic [TAG_W-1:0] tag);
		req_t rq;
		rq.func        = f;
		rq.request_tag = tag;
		start   <= 1'b1;
		request <= rq;
		do @(posedge clk); while (busy);
		sb.note_request(rq);
	endtask

	// Sender gap with start low; n, at least one, sets its length
	task automatic hold_off(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Sender pauses until every result due has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.due_results.size() != 0) @(posedge clk);
	endtask

	// Random function, leaning toward releases of whatever is held
	function automatic logic [2:0] pick_func();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (sb.excl_held && roll < 30)
			return F_UNLOCK_EX;
		if (sb.holders != 0 && roll < 40)
			return F_UNLOCK_SH;
		roll = $urandom_range(0, 99);
		if (roll < 27)
			return F_LOCK_EX;
		if (roll < 54)
			return F_LOCK_SH;
		if (roll < 62)
			return F_TRY_EX;
		if (roll < 70)
			return F_TRY_SH;
		if (roll < 82)
			return F_UNLOCK_EX;
		if (roll < 96)
			return F_UNLOCK_SH;
		return (roll < 98) ? F_UNDEF_LO : F_UNDEF_HI;
	endfunction

	// Random requests; the sender idles each cycle with the given chance in percent
	task automatic random_phase(input int gap_pct);
		repeat (ITEMS_PER_PHASE) begin
			while ($urandom_range(0, 99) < gap_pct)
				hold_off(1);
			issue(pick_func(), TAG_W'($urandom_range(0, 255)));
		end
	endtask

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && valid)
			sb.check_result(result);
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((start && !busy) || valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("reader_writer_lock_manager_top test failed");
			$finish;
		end
	end

	initial begin
		int i;
		sb = new();
		quiet_cycles = 0;
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Misuse, try requests and basic hand-over between modes
		issue(F_UNDEF_LO, 8'h00);
		issue(F_UNDEF_HI, 8'hFF);
		issue(F_UNLOCK_EX, 8'h11);
		issue(F_UNLOCK_SH, 8'h12);
		issue(F_TRY_SH, 8'h01);
		issue(F_TRY_EX, 8'h02);
		issue(F_UNLOCK_EX, 8'h03);
		issue(F_LOCK_EX, 8'hAA);
		issue(F_TRY_SH, 8'h04);
		issue(F_LOCK_SH, 8'h55);
		issue(F_UNLOCK_SH, 8'h01);
		issue(F_UNLOCK_SH, 8'h05);
		issue(F_UNLOCK_EX, 8'hAA);
		issue(F_LOCK_EX, 8'h06);
		issue(F_UNLOCK_SH, 8'h55);

		// Fill the queue with readers, overflow it, then release them all at once
		for (i = 0; i < QUEUE_DEPTH; i++)
			issue(F_LOCK_SH, TAG_W'(8'h80 + i));
		issue(F_LOCK_EX, 8'hFE);
		issue(F_LOCK_SH, 8'hFD);
		issue(F_UNLOCK_EX, 8'h06);
		for (i = 0; i < QUEUE_DEPTH; i++)
			issue(F_UNLOCK_SH, TAG_W'(8'h80 + i));
		issue(F_LOCK_SH, 8'h00);
		issue(F_UNLOCK_SH, 8'h00);
		issue(F_LOCK_EX, 8'hFF);
		issue(F_UNLOCK_EX, 8'hFF);
		drain();

		// Random traffic under three sender gap profiles
		random_phase(8);
		drain();
		random_phase(53);
		drain();
		random_phase(0);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.due_results.size() != 0)
			sb.fail_count++;
		if (sb.fail_count == 0)
			$display("reader_writer_lock_manager_top test passed");
		else
			$display("reader_writer_lock_manager_top test failed");
		$finish;
	end

endmodule
